// File: rtl/multimap_array_linked_lists_top_defines.svh
// assertion macros shared by the multimap rtl
`ifndef MULTIMAP_ARRAY_LINKED_LISTS_TOP_DEFINES_SVH
`define MULTIMAP_ARRAY_LINKED_LISTS_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define MMALL_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// property that must hold in the cycle after its trigger
`define MMALL_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

// File: rtl/mmall_pkg.sv
// shared types and constants of the multimap
package mmall_pkg;

   localparam int KEY_SLOTS_DEF  = 16;
   localparam int VALUE_POOL_DEF = 64;
   localparam int DATA_W         = 32;
   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 2;
   localparam int PAIR_W         = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD,
      CMD_REMOVE,
      CMD_SEARCH,
      CMD_NONE
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE,
      ST_MISS,
      ST_FULL
   } status_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_KREAD,
      OP_KSTEP,
      OP_KHIT,
      OP_SET_FULL,
      OP_SET_MISS,
      OP_KALLOC_RD,
      OP_KALLOC_WR,
      OP_ARD,
      OP_AWR,
      OP_VHEAD_RD,
      OP_VHEAD,
      OP_VREAD,
      OP_VSTEP,
      OP_VHIT,
      OP_EMIT,
      OP_RUNLINK,
      OP_RFREE,
      OP_KUNLINK,
      OP_KFREE,
      OP_RESP
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_KFIND,
      S_KCHK,
      S_DECIDE,
      S_KALLOC_RD,
      S_KALLOC_WR,
      S_ARD,
      S_AWR,
      S_VHEAD_RD,
      S_VHEAD,
      S_VFIND,
      S_VCHK,
      S_EMIT,
      S_RUNLINK,
      S_RFREE,
      S_KUNLINK,
      S_KFREE,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    found;
      logic    kcur_null;
      logic    key_match;
      logic    kfree_null;
      logic    vfree_null;
      logic    vcur_null;
      logic    val_match;
      logic    vlink_null;
      logic    list_empty;
      logic    out_free;
   } dp_status_type;

endpackage

// File: rtl/mmall_ram.sv
// generic single write port ram with registered read
module mmall_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/mmall_ctrl.sv
// sequencer of the multimap commands
`include "multimap_array_linked_lists_top_defines.svh"
module mmall_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mmall_pkg::dp_status_type status,
   output mmall_pkg::dp_cmd_type    dp_cmd
);
   import mmall_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_LOAD;
               state_in  = S_KFIND;
            end
         end
         S_KFIND: begin
            if (status.kcur_null) begin
               state_in = S_DECIDE;
            end else begin
               dp_cmd.op = OP_KREAD;
               state_in  = S_KCHK;
            end
         end
         S_KCHK: begin
            if (status.key_match) begin
               dp_cmd.op = OP_KHIT;
               state_in  = S_DECIDE;
            end else begin
               dp_cmd.op = OP_KSTEP;
               state_in  = S_KFIND;
            end
         end
         S_DECIDE: begin
            case (status.cmd)
               CMD_ADD: begin
                  if (status.vfree_null || (!status.found && status.kfree_null)) begin
                     dp_cmd.op = OP_SET_FULL;
                     state_in  = S_RESP;
                  end else if (status.found) begin
                     state_in = S_ARD;
                  end else begin
                     state_in = S_KALLOC_RD;
                  end
               end
               CMD_REMOVE, CMD_SEARCH: begin
                  if (status.found) begin
                     state_in = S_VHEAD_RD;
                  end else begin
                     dp_cmd.op = OP_SET_MISS;
                     state_in  = S_RESP;
                  end
               end
               default: begin
                  dp_cmd.op = OP_SET_MISS;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_KALLOC_RD: begin
            dp_cmd.op = OP_KALLOC_RD;
            state_in  = S_KALLOC_WR;
         end
         S_KALLOC_WR: begin
            dp_cmd.op = OP_KALLOC_WR;
            state_in  = S_ARD;
         end
         S_ARD: begin
            dp_cmd.op = OP_ARD;
            state_in  = S_AWR;
         end
         S_AWR: begin
            dp_cmd.op = OP_AWR;
            state_in  = S_RESP;
         end
         S_VHEAD_RD: begin
            dp_cmd.op = OP_VHEAD_RD;
            state_in  = S_VHEAD;
         end
         S_VHEAD: begin
            dp_cmd.op = OP_VHEAD;
            state_in  = S_VFIND;
         end
         S_VFIND: begin
            if (status.vcur_null) begin
               dp_cmd.op = OP_SET_MISS;
               state_in  = S_RESP;
            end else begin
               dp_cmd.op = OP_VREAD;
               state_in  = S_VCHK;
            end
         end
         S_VCHK: begin
            if (status.cmd == CMD_SEARCH) begin
               state_in = S_EMIT;
            end else if (status.val_match) begin
               dp_cmd.op = OP_VHIT;
               state_in  = S_RUNLINK;
            end else begin
               dp_cmd.op = OP_VSTEP;
               state_in  = S_VFIND;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               dp_cmd.op = OP_EMIT;
               state_in  = status.vlink_null ? S_IDLE : S_VFIND;
            end
         end
         S_RUNLINK: begin
            dp_cmd.op = OP_RUNLINK;
            state_in  = S_RFREE;
         end
         S_RFREE: begin
            dp_cmd.op = OP_RFREE;
            state_in  = status.list_empty ? S_KUNLINK : S_RESP;
         end
         S_KUNLINK: begin
            dp_cmd.op = OP_KUNLINK;
            state_in  = S_KFREE;
         end
         S_KFREE: begin
            dp_cmd.op = OP_KFREE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               dp_cmd.op = OP_RESP;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   `MMALL_ASSERT_NEXT(a_last_ends_search,
      state_ff == S_EMIT && status.out_free && status.vlink_null, state_ff == S_IDLE,
      "final search value did not end the transaction")
   `MMALL_ASSERT_NEXT(a_full_add_responds,
      state_ff == S_DECIDE && status.cmd == CMD_ADD && status.vfree_null,
      state_ff == S_RESP, "add on a full pool did not go to response")
   `MMALL_ASSERT_NEXT(a_miss_responds,
      state_ff == S_DECIDE && !status.found && status.cmd == CMD_REMOVE,
      state_ff == S_RESP, "remove of a missing key did not go to response")
endmodule

// File: rtl/mmall_dp.sv
// datapath of the multimap: list pointers, stores and result register
`include "multimap_array_linked_lists_top_defines.svh"
module mmall_dp #(
   parameter int KEY_SLOTS  = mmall_pkg::KEY_SLOTS_DEF,
   parameter int VALUE_POOL = mmall_pkg::VALUE_POOL_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mmall_pkg::dp_cmd_type                 dp_cmd,
   output mmall_pkg::dp_status_type              status,
   input  logic [mmall_pkg::CMD_W-1:0]           req_command,
   input  logic signed [mmall_pkg::DATA_W-1:0]   req_key_in,
   input  logic signed [mmall_pkg::DATA_W-1:0]   req_value_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mmall_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mmall_pkg::DATA_W-1:0]   rsp_value_out,
   output logic                                  rsp_value_valid,
   output logic                                  rsp_last,
   output logic [mmall_pkg::PAIR_W-1:0]          rsp_pair_total
);
   import mmall_pkg::*;

   localparam int KIW = $clog2(KEY_SLOTS);
   localparam int KLW = $clog2(KEY_SLOTS + 1);
   localparam int VIW = $clog2(VALUE_POOL);
   localparam int VLW = $clog2(VALUE_POOL + 1);
   localparam logic [KLW-1:0] KNIL = KLW'(KEY_SLOTS);
   localparam logic [VLW-1:0] VNIL = VLW'(VALUE_POOL);

   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] item_key_ff, item_key_in, item_val_ff, item_val_in;
   logic [KLW-1:0]    kcur_ff, kcur_in, kprev_ff, kprev_in, slot_ff, slot_in;
   logic [KLW-1:0]    knext_ff, knext_in;
   logic [KLW-1:0]    klist_ff, klist_in, kfree_ff, kfree_in, kfresh_ff, kfresh_in;
   logic [VLW-1:0]    vcur_ff, vcur_in, vprev_ff, vprev_in, vnext_ff, vnext_in;
   logic [VLW-1:0]    vfree_ff, vfree_in, vfresh_ff, vfresh_in, pair_ff, pair_in;
   logic              found_ff, found_in, newkey_ff, newkey_in;
   status_type        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_vv_ff, rsp_vv_in;
   logic              rsp_last_ff, rsp_last_in;
   status_type        rsp_st_ff, rsp_st_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;
   logic [PAIR_W-1:0] rsp_pair_ff, rsp_pair_in;

   // store ports
   logic              kstore_we, klink_we, kvh_we, vstore_we, vlink_we;
   logic [KIW-1:0]    kstore_wa, klink_wa, kvh_wa, klink_ra;
   logic [VIW-1:0]    vstore_wa, vlink_wa, vlink_ra;
   logic [KLW-1:0]    klink_wd;
   logic [VLW-1:0]    kvh_wd, vlink_wd;
   logic [DATA_W-1:0] kstore_q, vstore_q;
   logic [KLW-1:0]    klink_q;
   logic [VLW-1:0]    kvh_q, vlink_q;
   logic              out_free;

   mmall_ram #(.WIDTH(DATA_W), .DEPTH(KEY_SLOTS)) u_key_store (
      .clock(clock), .we(kstore_we), .waddr(kstore_wa), .wdata(item_key_ff),
      .raddr(kcur_ff[KIW-1:0]), .rdata(kstore_q));
   mmall_ram #(.WIDTH(KLW), .DEPTH(KEY_SLOTS)) u_key_link (
      .clock(clock), .we(klink_we), .waddr(klink_wa), .wdata(klink_wd),
      .raddr(klink_ra), .rdata(klink_q));
   mmall_ram #(.WIDTH(VLW), .DEPTH(KEY_SLOTS)) u_key_value_head (
      .clock(clock), .we(kvh_we), .waddr(kvh_wa), .wdata(kvh_wd),
      .raddr(slot_ff[KIW-1:0]), .rdata(kvh_q));
   mmall_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_POOL)) u_value_store (
      .clock(clock), .we(vstore_we), .waddr(vstore_wa), .wdata(item_val_ff),
      .raddr(vcur_ff[VIW-1:0]), .rdata(vstore_q));
   mmall_ram #(.WIDTH(VLW), .DEPTH(VALUE_POOL)) u_value_link (
      .clock(clock), .we(vlink_we), .waddr(vlink_wa), .wdata(vlink_wd),
      .raddr(vlink_ra), .rdata(vlink_q));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign klink_ra = (dp_cmd.op == OP_KALLOC_RD) ? kfree_ff[KIW-1:0] : kcur_ff[KIW-1:0];
   assign vlink_ra = (dp_cmd.op == OP_ARD) ? vfree_ff[VIW-1:0] : vcur_ff[VIW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         klist_ff     <= KNIL;
         kfree_ff     <= '0;
         kfresh_ff    <= '0;
         vfree_ff     <= '0;
         vfresh_ff    <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         klist_ff     <= klist_in;
         kfree_ff     <= kfree_in;
         kfresh_ff    <= kfresh_in;
         vfree_ff     <= vfree_in;
         vfresh_ff    <= vfresh_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      item_key_ff <= item_key_in;
      item_val_ff <= item_val_in;
      kcur_ff     <= kcur_in;
      kprev_ff    <= kprev_in;
      slot_ff     <= slot_in;
      knext_ff    <= knext_in;
      vcur_ff     <= vcur_in;
      vprev_ff    <= vprev_in;
      vnext_ff    <= vnext_in;
      found_ff    <= found_in;
      newkey_ff   <= newkey_in;
      st_ff       <= st_in;
      rsp_vv_ff   <= rsp_vv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_pair_ff <= rsp_pair_in;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      item_key_in  = item_key_ff;
      item_val_in  = item_val_ff;
      kcur_in      = kcur_ff;
      kprev_in     = kprev_ff;
      slot_in      = slot_ff;
      knext_in     = knext_ff;
      klist_in     = klist_ff;
      kfree_in     = kfree_ff;
      kfresh_in    = kfresh_ff;
      vcur_in      = vcur_ff;
      vprev_in     = vprev_ff;
      vnext_in     = vnext_ff;
      vfree_in     = vfree_ff;
      vfresh_in    = vfresh_ff;
      pair_in      = pair_ff;
      found_in     = found_ff;
      newkey_in    = newkey_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vv_in    = rsp_vv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_pair_in  = rsp_pair_ff;
      kstore_we    = 1'b0;
      kstore_wa    = kfree_ff[KIW-1:0];
      klink_we     = 1'b0;
      klink_wa     = slot_ff[KIW-1:0];
      klink_wd     = kfree_ff;
      kvh_we       = 1'b0;
      kvh_wa       = slot_ff[KIW-1:0];
      kvh_wd       = vfree_ff;
      vstore_we    = 1'b0;
      vstore_wa    = vfree_ff[VIW-1:0];
      vlink_we     = 1'b0;
      vlink_wa     = vcur_ff[VIW-1:0];
      vlink_wd     = vfree_ff;
      case (dp_cmd.op)
         OP_LOAD: begin
            cmd_in      = cmd_type'(req_command);
            item_key_in = req_key_in;
            item_val_in = req_value_in;
            kcur_in     = klist_ff;
            kprev_in    = KNIL;
            found_in    = 1'b0;
            newkey_in   = 1'b0;
            st_in       = ST_DONE;
         end
         OP_KSTEP: begin
            kprev_in = kcur_ff;
            kcur_in  = klink_q;
         end
         OP_KHIT: begin
            found_in = 1'b1;
            slot_in  = kcur_ff;
            knext_in = klink_q;
         end
         OP_SET_FULL: st_in = ST_FULL;
         OP_SET_MISS: st_in = ST_MISS;
         OP_KALLOC_WR: begin
            // a slot at the fresh mark was never linked: its successor is the next index
            slot_in = kfree_ff;
            if (kfree_ff == kfresh_ff) begin
               kfree_in  = kfree_ff + KLW'(1);
               kfresh_in = kfresh_ff + KLW'(1);
            end else begin
               kfree_in = klink_q;
            end
            kstore_we = 1'b1;
            klink_we  = 1'b1;
            klink_wa  = kfree_ff[KIW-1:0];
            klink_wd  = klist_ff;
            klist_in  = kfree_ff;
            newkey_in = 1'b1;
         end
         OP_AWR: begin
            if (vfree_ff == vfresh_ff) begin
               vfree_in  = vfree_ff + VLW'(1);
               vfresh_in = vfresh_ff + VLW'(1);
            end else begin
               vfree_in = vlink_q;
            end
            vstore_we = 1'b1;
            vlink_we  = 1'b1;
            vlink_wa  = vfree_ff[VIW-1:0];
            vlink_wd  = newkey_ff ? VNIL : kvh_q;
            kvh_we    = 1'b1;
            pair_in   = pair_ff + VLW'(1);
         end
         OP_VHEAD: begin
            vcur_in  = kvh_q;
            vprev_in = VNIL;
         end
         OP_VSTEP: begin
            vprev_in = vcur_ff;
            vcur_in  = vlink_q;
         end
         OP_VHIT: vnext_in = vlink_q;
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_st_in    = ST_DONE;
            rsp_val_in   = vstore_q;
            rsp_vv_in    = 1'b1;
            rsp_last_in  = (vlink_q == VNIL);
            rsp_pair_in  = PAIR_W'(pair_ff);
            vcur_in      = vlink_q;
         end
         OP_RUNLINK: begin
            if (vprev_ff == VNIL) begin
               kvh_we = 1'b1;
               kvh_wd = vnext_ff;
            end else begin
               vlink_we = 1'b1;
               vlink_wa = vprev_ff[VIW-1:0];
               vlink_wd = vnext_ff;
            end
         end
         OP_RFREE: begin
            vlink_we = 1'b1;
            vfree_in = vcur_ff;
            if (pair_ff != '0) begin
               pair_in = pair_ff - VLW'(1);
            end
         end
         OP_KUNLINK: begin
            if (kprev_ff == KNIL) begin
               klist_in = knext_ff;
            end else begin
               klink_we = 1'b1;
               klink_wa = kprev_ff[KIW-1:0];
               klink_wd = knext_ff;
            end
         end
         OP_KFREE: begin
            klink_we = 1'b1;
            kfree_in = slot_ff;
         end
         OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_st_in    = st_ff;
            rsp_val_in   = '0;
            rsp_vv_in    = 1'b0;
            rsp_last_in  = 1'b1;
            rsp_pair_in  = PAIR_W'(pair_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.cmd        = cmd_ff;
      status.found      = found_ff;
      status.kcur_null  = (kcur_ff == KNIL);
      status.key_match  = (kstore_q == item_key_ff);
      status.kfree_null = (kfree_ff == KNIL);
      status.vfree_null = (vfree_ff == VNIL);
      status.vcur_null  = (vcur_ff == VNIL);
      status.val_match  = (vstore_q == item_val_ff);
      status.vlink_null = (vlink_q == VNIL);
      status.list_empty = (vprev_ff == VNIL) && (vnext_ff == VNIL);
      status.out_free   = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_value_out   = rsp_val_ff;
   assign rsp_value_valid = rsp_vv_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_pair_total  = rsp_pair_ff;

   `MMALL_ASSERT_HOLDS(a_pair_bound, pair_ff <= VNIL, "pair count above pool size")
   `MMALL_ASSERT_HOLDS(a_vfree_fresh, vfree_ff <= vfresh_ff || vfree_ff == VNIL,
      "value free head beyond fresh mark")
   `MMALL_ASSERT_HOLDS(a_kfree_fresh, kfree_ff <= kfresh_ff || kfree_ff == KNIL,
      "key free head beyond fresh mark")
endmodule

// File: rtl/multimap_array_linked_lists_top.sv
// Multimap of 32-bit key and value pairs kept as linked lists in on-chip stores.
// One transaction at a time: req_stall is high from acceptance until the last
// result is handed to the output register. Every link visit is one registered store
// read and one compare; an add walks the key list, a remove the key list and the
// value list, and a search the key list and then emits each value. No clearing
// pass after reset: the free lists start from fresh marks that hand out untouched
// entries in order.
module multimap_array_linked_lists_top #(
   parameter int KEY_SLOTS  = mmall_pkg::KEY_SLOTS_DEF,
   parameter int VALUE_POOL = mmall_pkg::VALUE_POOL_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request transaction
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mmall_pkg::CMD_W-1:0]         req_command,
   input  logic signed [mmall_pkg::DATA_W-1:0] req_key_in,
   input  logic signed [mmall_pkg::DATA_W-1:0] req_value_in,
   // result transaction
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mmall_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [mmall_pkg::DATA_W-1:0] rsp_value_out,
   output logic                                rsp_value_valid,
   output logic                                rsp_last,
   output logic [mmall_pkg::PAIR_W-1:0]        rsp_pair_total
);
   import mmall_pkg::*;

   // micro-op from the sequencer, flags back from the datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mmall_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .dp_cmd    (dp_cmd)
   );

   mmall_dp #(
      .KEY_SLOTS  (KEY_SLOTS),
      .VALUE_POOL (VALUE_POOL)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .status          (dp_status),
      .req_command     (req_command),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_value_valid (rsp_value_valid),
      .rsp_last        (rsp_last),
      .rsp_pair_total  (rsp_pair_total)
   );
endmodule

// File: test/tb_multimap_array_linked_lists_top.sv
// self-checking testbench of the multimap with a golden list model and scoreboard
module tb_multimap_array_linked_lists_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mmall_pkg::*;

   localparam int KSLOTS = KEY_SLOTS_DEF;
   localparam int VPOOL  = VALUE_POOL_DEF;
   localparam int KNULL  = KSLOTS;
   localparam int VNULL  = VPOOL;
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct packed {
      cmd_type          command;
      logic [DATA_W-1:0] key_in;
      logic [DATA_W-1:0] value_in;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] value_out;
      logic              value_valid;
      logic              last;
      logic [PAIR_W-1:0] pair_total;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic signed [DATA_W-1:0] req_key_in = '0;
   logic signed [DATA_W-1:0] req_value_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic rsp_value_valid;
   logic rsp_last;
   logic [PAIR_W-1:0] rsp_pair_total;

   multimap_array_linked_lists_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // golden copy of the stores
   logic [DATA_W-1:0] mdl_key [KSLOTS];
   int                mdl_klink [KSLOTS];
   int                mdl_vhead [KSLOTS];
   int                mdl_khead, mdl_kfree;
   logic [DATA_W-1:0] mdl_val [VPOOL];
   int                mdl_vlink [VPOOL];
   int                mdl_vfree;
   int                mdl_pairs;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  fail_count = 0;
   longint cycle_count = 0;

   function automatic void expect_rsp(rsp_item_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic int find_key_slot(logic [DATA_W-1:0] k);
      int cur;
      cur = mdl_khead;
      for (int n = 0; n < KSLOTS && cur < KNULL; n++) begin
         if (mdl_key[cur] == k) return cur;
         cur = mdl_klink[cur];
      end
      return KNULL;
   endfunction

   function automatic rsp_item_type mk_rsp(status_type st, logic [DATA_W-1:0] v, logic vv,
                                           logic lst);
      rsp_item_type r;
      r.status = st;
      r.value_out = v;
      r.value_valid = vv;
      r.last = lst;
      r.pair_total = mdl_pairs[PAIR_W-1:0];
      return r;
   endfunction

   function automatic void push_pair(int slot, logic [DATA_W-1:0] v);
      int e;
      e = mdl_vfree;
      mdl_vfree = mdl_vlink[e];
      mdl_val[e] = v;
      mdl_vlink[e] = mdl_vhead[slot];
      mdl_vhead[slot] = e;
      mdl_pairs++;
   endfunction

   function automatic status_type add_pair(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      int slot;
      slot = find_key_slot(k);
      if (mdl_vfree >= VNULL) return ST_FULL;
      if (slot < KNULL) begin
         push_pair(slot, v);
         return ST_DONE;
      end
      if (mdl_kfree >= KNULL) return ST_FULL;
      slot = mdl_kfree;
      mdl_kfree = mdl_klink[slot];
      mdl_key[slot] = k;
      mdl_vhead[slot] = VNULL;
      mdl_klink[slot] = mdl_khead;
      mdl_khead = slot;
      push_pair(slot, v);
      return ST_DONE;
   endfunction

   function automatic status_type remove_pair(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      int slot, cur, prev, kc, kp;
      slot = find_key_slot(k);
      prev = VNULL;
      if (slot >= KNULL) return ST_MISS;
      cur = mdl_vhead[slot];
      while (cur < VNULL && mdl_val[cur] != v) begin
         prev = cur;
         cur = mdl_vlink[cur];
      end
      if (cur >= VNULL) return ST_MISS;
      if (prev >= VNULL) mdl_vhead[slot] = mdl_vlink[cur];
      else mdl_vlink[prev] = mdl_vlink[cur];
      mdl_vlink[cur] = mdl_vfree;
      mdl_vfree = cur;
      if (mdl_pairs > 0) mdl_pairs--;
      // an emptied key slot goes back on the free list
      if (mdl_vhead[slot] >= VNULL) begin
         kc = mdl_khead;
         kp = KNULL;
         while (kc < KNULL && kc != slot) begin
            kp = kc;
            kc = mdl_klink[kc];
         end
         if (kc == slot) begin
            if (kp >= KNULL) mdl_khead = mdl_klink[kc];
            else mdl_klink[kp] = mdl_klink[kc];
            mdl_klink[kc] = mdl_kfree;
            mdl_kfree = kc;
         end
      end
      return ST_DONE;
   endfunction

   // update the golden stores and queue every result one transaction causes
   function automatic void predict_multimap(req_item_type it);
      int slot, cur, nx, n;
      case (it.command)
         CMD_ADD: begin
            expect_rsp(mk_rsp(add_pair(it.key_in, it.value_in), '0, 1'b0, 1'b1));
         end
         CMD_REMOVE: begin
            expect_rsp(mk_rsp(remove_pair(it.key_in, it.value_in), '0, 1'b0, 1'b1));
         end
         CMD_SEARCH: begin
            slot = find_key_slot(it.key_in);
            if (slot >= KNULL || mdl_vhead[slot] >= VNULL) begin
               expect_rsp(mk_rsp(ST_MISS, '0, 1'b0, 1'b1));
            end else begin
               cur = mdl_vhead[slot];
               n = 0;
               while (n < VPOOL && cur < VNULL) begin
                  nx = mdl_vlink[cur];
                  expect_rsp(mk_rsp(ST_DONE, mdl_val[cur], 1'b1,
                                    (nx >= VNULL) || (n + 1 >= VPOOL)));
                  cur = nx;
                  n++;
               end
            end
         end
         default: begin
            expect_rsp(mk_rsp(ST_MISS, '0, 1'b0, 1'b1));
         end
      endcase
   endfunction

   // driver: pops the next pending transaction, holds it while stalled
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_multimap(req_item_type'{cmd_type'(req_command), req_key_in,
                                            req_value_in});
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item_type nxt;
               nxt = pending_reqs.pop_front();
               req_valid    <= 1'b1;
               req_command  <= nxt.command;
               req_key_in   <= nxt.key_in;
               req_value_in <= nxt.value_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: compares each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected result exp none got status=%0d value=%0h", $realtime,
                     rsp_status, rsp_value_out);
            fail_count++;
         end else begin
            rsp_item_type exp_r;
            exp_r = expected_rsps.pop_front();
            if (rsp_status !== exp_r.status) begin
               $display("%0t status exp %0d got %0d", $realtime, exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_value_out !== exp_r.value_out) begin
               $display("%0t value_out exp %0h got %0h", $realtime, exp_r.value_out,
                        rsp_value_out);
               fail_count++;
            end
            if (rsp_value_valid !== exp_r.value_valid) begin
               $display("%0t value_valid exp %0b got %0b", $realtime, exp_r.value_valid,
                        rsp_value_valid);
               fail_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $display("%0t last exp %0b got %0b", $realtime, exp_r.last, rsp_last);
               fail_count++;
            end
            if (rsp_pair_total !== exp_r.pair_total) begin
               $display("%0t pair_total exp %0d got %0d", $realtime, exp_r.pair_total,
                        rsp_pair_total);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // small key set so adds hit known keys and removes find values
   logic [DATA_W-1:0] key_pool [8];
   logic [DATA_W-1:0] val_pool [8];

   function automatic logic [DATA_W-1:0] rnd32();
      return $urandom;
   endfunction

   task automatic queue_req(cmd_type c, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      pending_reqs.insert(pending_reqs.size(), req_item_type'{c, k, v});
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_phase(int n_items, int add_bias);
      int r;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < add_bias)
            queue_req(CMD_ADD, key_pool[$urandom_range(7)],
                      ($urandom_range(3) == 0) ? rnd32() : val_pool[$urandom_range(7)]);
         else if (r < add_bias + 25)
            queue_req(CMD_REMOVE, key_pool[$urandom_range(7)],
                      ($urandom_range(7) == 0) ? rnd32() : val_pool[$urandom_range(7)]);
         else if (r < 97)
            queue_req(CMD_SEARCH, ($urandom_range(9) == 0) ? rnd32()
                                                          : key_pool[$urandom_range(7)],
                      rnd32());
         else
            queue_req(CMD_NONE, rnd32(), rnd32());
      end
   endtask

   initial begin
      for (int i = 0; i < KSLOTS; i++) begin
         mdl_key[i] = '0;
         mdl_klink[i] = i + 1;
         mdl_vhead[i] = VNULL;
      end
      for (int i = 0; i < VPOOL; i++) begin
         mdl_val[i] = '0;
         mdl_vlink[i] = i + 1;
      end
      mdl_khead = KNULL;
      mdl_kfree = 0;
      mdl_vfree = 0;
      mdl_pairs = 0;
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = rnd32();
         val_pool[i] = rnd32();
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      val_pool[0] = 32'hffff_ffff;
      val_pool[1] = 32'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, misses on empty store, duplicates, unknown command
      queue_req(CMD_SEARCH, key_pool[0], '0);
      queue_req(CMD_REMOVE, key_pool[0], val_pool[0]);
      queue_req(CMD_ADD, key_pool[0], val_pool[0]);
      queue_req(CMD_ADD, key_pool[0], val_pool[1]);
      queue_req(CMD_ADD, key_pool[0], val_pool[0]);
      queue_req(CMD_ADD, key_pool[1], 32'h7fff_ffff);
      queue_req(CMD_SEARCH, key_pool[0], '1);
      queue_req(CMD_REMOVE, key_pool[0], 32'h1234_5678);
      queue_req(CMD_REMOVE, key_pool[0], val_pool[0]);
      queue_req(CMD_SEARCH, key_pool[0], '0);
      queue_req(CMD_REMOVE, key_pool[1], 32'h7fff_ffff);
      queue_req(CMD_SEARCH, key_pool[1], '0);
      queue_req(CMD_NONE, '1, '1);
      // fill the key slots to see a full report on a new key
      for (int i = 0; i < KSLOTS + 1; i++) queue_req(CMD_ADD, 32'h100 + i, i);
      // sender waits until every expected result has come
      drain();
      // fill the pool to see a full report on a known key
      for (int i = 0; i < VPOOL; i++) queue_req(CMD_ADD, 32'h100, 32'hA000 + i);
      queue_req(CMD_SEARCH, 32'h100, '0);
      for (int i = 0; i < KSLOTS; i++) queue_req(CMD_SEARCH, 32'h100 + i, '0);
      drain();
      // remove the pairs that the fills added
      for (int i = 0; i < KSLOTS; i++) queue_req(CMD_REMOVE, 32'h100 + i, i);
      for (int i = 0; i < VPOOL; i++) queue_req(CMD_REMOVE, 32'h100, 32'hA000 + i);
      drain();

      // random phases with each idling mix
      random_phase(80, 45);
      drain();
      send_idle_pct = 50;
      random_phase(75, 40);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 50;
      random_phase(75, 40);
      drain();
      send_idle_pct = 32;
      recv_stall_pct = 32;
      random_phase(80, 35);
      drain();

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: multimap_array_linked_lists_top.f
+incdir+rtl
rtl/mmall_pkg.sv
rtl/mmall_ram.sv
rtl/mmall_ctrl.sv
rtl/mmall_dp.sv
rtl/multimap_array_linked_lists_top.sv
test/tb_multimap_array_linked_lists_top.sv
